// ===== rtl/core/anti_replay_window_check_core_defines.svh =====
// ----------------------------------------------------------------------------
// Anti-replay window check: assertion macros
// Shared property wrappers for the checker files of the core.
// ----------------------------------------------------------------------------
`ifndef ANTI_REPLAY_WINDOW_CHECK_CORE_DEFINES_SVH
`define ANTI_REPLAY_WINDOW_CHECK_CORE_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define ARWC_ASSERT_NOW(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: property violated");

// next-cycle implication, disabled while reset is asserted
`define ARWC_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: property violated");

`endif

// ===== rtl/core/arwc_pkg.sv =====
// ----------------------------------------------------------------------------
// Anti-replay window check: package
// Fixed widths, controller states and verdict codes.
// ----------------------------------------------------------------------------
package arwc_pkg;

    // sequence number and bitmap word geometry
    localparam int SEQ_W  = 64;
    localparam int WORD_W = 64;
    localparam int BIT_W  = 6;

    // controller states
    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_WAIT,
        ST_SWEEP,
        ST_DRAIN,
        ST_TEST,
        ST_OUT
    } t_state;

    // result codes
    typedef enum logic [1:0] {
        VERDICT_OK   = 2'd0,
        VERDICT_ZERO = 2'd1,
        VERDICT_OLD  = 2'd2,
        VERDICT_DUP  = 2'd3
    } t_verdict;

endpackage

// ===== rtl/core/arwc_ram.sv =====
// ----------------------------------------------------------------------------
// Anti-replay window check: generic RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module arwc_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                                      i_clk,
    input  logic                                      i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                          i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                          o_rdata
);

    logic [WIDTH-1:0] r_mem [0:DEPTH-1];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/arwc_mod.sv =====
// ----------------------------------------------------------------------------
// Anti-replay window check: window position unit
// Window position of a sequence number for a power-of-two window, presented
// with a done strobe that is delayed to line up with the core's compares.
// ----------------------------------------------------------------------------
module arwc_mod
    import arwc_pkg::*;
#(
    parameter int WINDOW_BITS = 1024
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [$clog2(WINDOW_BITS)-1:0] i_dividend,
    output logic                           o_done,
    output logic [$clog2(WINDOW_BITS)-1:0] o_rem
);

    localparam int PW  = $clog2(WINDOW_BITS);
    // start-to-done delay, matched to the window compares in the core
    localparam int LAT = 3;

    logic [LAT-1:0] r_pipe;
    logic [PW-1:0]  r_rem;

    // done strobe: start delayed through the r_pipe shift register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pipe <= '0;
        end else begin
            r_pipe <= {r_pipe[LAT-2:0], i_start};
        end
    end

    // position is the low bits of the number
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_dividend;
        end
    end

    assign o_done = r_pipe[LAT-1];
    assign o_rem  = r_rem;

endmodule

// ===== rtl/core/anti_replay_window_check_core.sv =====
// ----------------------------------------------------------------------------
// Anti-replay window check core
// Sliding-window replay filter for received packet sequence numbers, with
// the window bitmap held in a word-wide RAM.
// ----------------------------------------------------------------------------
// One sequence number is checked at a time. WINDOW_BITS must be a power of
// two, so the window position of a number is its low bits. After reset the
// core clears the bitmap RAM, one word per cycle, all WORD_COUNT words (16 at
// the default window), before it raises o_in_ready. Each item is registered,
// compared against the highest number and then against the window before its
// decision. A zero or too-old number goes straight to the result; a number at
// or below the highest takes one read-modify-write of its bitmap word; a new
// highest number sweeps the whole bitmap RAM word by word to clear the skipped
// span. o_in_ready rises with the result, so the next transfer can be taken
// while the result is shown. The result register lets the next item enter
// while a result waits; an item only stalls in its last cycle while the
// previous result is still unread.
module anti_replay_window_check_core
    import arwc_pkg::*;
#(
    parameter int WINDOW_BITS = 1024
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic [SEQ_W-1:0] i_seq_number,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic             o_accepted,
    output logic [1:0]       o_verdict
);

    localparam int WORD_COUNT = (WINDOW_BITS + WORD_W - 1) / WORD_W;
    localparam int PW         = $clog2(WINDOW_BITS);
    localparam int WAW        = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
    localparam int PXW        = WAW + BIT_W;

    t_state           r_state;
    t_state           n_state;
    logic [SEQ_W-1:0] r_seq;
    logic [SEQ_W-1:0] r_highest;
    logic [PW-1:0]    r_hp;
    logic [PW-1:0]    r_pos;
    logic [PW-1:0]    r_start;
    logic [PW-1:0]    r_end;
    logic             r_all;
    logic             r_zero;
    logic             r_gt;
    logic [SEQ_W-1:0] r_up;
    logic [SEQ_W-1:0] r_dn;
    logic             r_old;
    logic             r_big;
    logic [WAW-1:0]   r_cnt;
    logic [WAW-1:0]   r_widx;
    logic             r_wv;
    t_verdict         r_verdict;
    logic             r_o_valid;
    t_verdict         r_o_verdict;

    logic              in_xfer;
    logic              out_free;
    logic              mod_done;
    logic [PW-1:0]     mod_rem;
    logic [PW:0]       hp_inc;
    logic [PW-1:0]     hp_next;
    logic [WAW-1:0]    rem_word;
    logic [WAW-1:0]    pos_word;
    logic [WORD_W-1:0] set_mask;
    logic [WORD_W-1:0] clr_mask;
    logic              ram_we;
    logic [WAW-1:0]    ram_waddr;
    logic [WORD_W-1:0] ram_wdata;
    logic [WAW-1:0]    ram_raddr;
    logic [WORD_W-1:0] ram_rdata;

    assign in_xfer  = i_in_valid && o_in_ready;
    assign out_free = !r_o_valid || i_out_ready;

    // window position of the incoming number
    arwc_mod #(
        .WINDOW_BITS(WINDOW_BITS)
    ) u_mod (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (in_xfer),
        .i_dividend(i_seq_number[PW-1:0]),
        .o_done    (mod_done),
        .o_rem     (mod_rem)
    );

    // window bitmap storage
    arwc_ram #(
        .WIDTH(WORD_W),
        .DEPTH(WORD_COUNT)
    ) u_bitmap (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    // position helpers
    assign hp_inc   = {1'b0, r_hp} + (PW + 1)'(1);
    assign hp_next  = (hp_inc == (PW + 1)'(WINDOW_BITS)) ? '0 : hp_inc[PW-1:0];
    assign rem_word = WAW'(PXW'(mod_rem) >> BIT_W);
    assign pos_word = WAW'(PXW'(r_pos) >> BIT_W);
    assign set_mask = WORD_W'(1) << r_pos[BIT_W-1:0];

    // clear mask of the skipped span within the word under write
    always_comb begin
        logic [PXW-1:0] p;
        logic [PXW-1:0] s_x;
        logic [PXW-1:0] e_x;
        logic           in_rng;
        s_x = PXW'(r_start);
        e_x = PXW'(r_end);
        for (int b = 0; b < WORD_W; b++) begin
            p = {r_widx, BIT_W'(b)};
            if (s_x <= e_x) begin
                in_rng = (p >= s_x) && (p <= e_x);
            end else begin
                in_rng = (p >= s_x) || (p <= e_x);
            end
            clr_mask[b] = r_all || in_rng;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_INIT: begin
                if (r_cnt == WAW'(WORD_COUNT - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_xfer) begin
                    n_state = ST_WAIT;
                end
            end
            ST_WAIT: begin
                if (mod_done) begin
                    if (r_zero || (!r_gt && r_old)) begin
                        n_state = ST_OUT;
                    end else if (r_gt) begin
                        n_state = ST_SWEEP;
                    end else begin
                        n_state = ST_TEST;
                    end
                end
            end
            ST_SWEEP: begin
                if (r_cnt == WAW'(WORD_COUNT - 1)) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: n_state = ST_OUT;
            ST_TEST:  n_state = ST_OUT;
            ST_OUT: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default:  n_state = ST_INIT;
        endcase
    end

    // ram port control
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_widx;
        ram_wdata = '0;
        ram_raddr = rem_word;
        case (r_state)
            ST_INIT: begin
                ram_we    = 1'b1;
                ram_waddr = r_cnt;
            end
            ST_SWEEP, ST_DRAIN: begin
                if (r_state == ST_SWEEP) begin
                    ram_raddr = r_cnt;
                end
                ram_we    = r_wv;
                ram_wdata = (ram_rdata & ~clr_mask) | ((r_widx == pos_word) ? set_mask : '0);
            end
            ST_TEST: begin
                ram_we    = 1'b1;
                ram_waddr = pos_word;
                ram_wdata = ram_rdata | set_mask;
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_INIT;
            r_cnt     <= '0;
            r_highest <= '0;
            r_hp      <= '0;
            r_wv      <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_wv    <= (r_state == ST_SWEEP);
            if (r_state == ST_INIT || r_state == ST_SWEEP) begin
                r_cnt <= r_cnt + WAW'(1);
            end else begin
                r_cnt <= '0;
            end
            if (r_state == ST_WAIT && mod_done && !r_zero && r_gt) begin
                r_highest <= r_seq;
                r_hp      <= mod_rem;
            end
            if (r_state == ST_OUT && out_free) begin
                r_o_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // item datapath
    always_ff @(posedge i_clk) begin
        logic [SEQ_W:0] up_ext;
        up_ext = {1'b0, r_highest} - {1'b0, r_seq};
        if (in_xfer) begin
            r_seq <= i_seq_number;
        end
        // compare against the highest, then against the window
        r_zero <= (r_seq == '0);
        r_gt   <= up_ext[SEQ_W];
        r_up   <= up_ext[SEQ_W-1:0];
        r_dn   <= r_seq - r_highest;
        r_old  <= (r_up >= SEQ_W'(WINDOW_BITS));
        r_big  <= (r_dn >= SEQ_W'(WINDOW_BITS));
        r_widx <= r_cnt;
        if (r_state == ST_WAIT && mod_done) begin
            r_pos   <= mod_rem;
            r_start <= hp_next;
            r_end   <= mod_rem;
            r_all   <= r_big;
            if (r_zero) begin
                r_verdict <= VERDICT_ZERO;
            end else if (r_gt) begin
                r_verdict <= VERDICT_OK;
            end else if (r_old) begin
                r_verdict <= VERDICT_OLD;
            end
        end
        if (r_state == ST_TEST) begin
            r_verdict <= ram_rdata[r_pos[BIT_W-1:0]] ? VERDICT_DUP : VERDICT_OK;
        end
        if (r_state == ST_OUT && out_free) begin
            r_o_verdict <= r_verdict;
        end
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_o_valid;
    assign o_verdict   = r_o_verdict;
    assign o_accepted  = (r_o_verdict == VERDICT_OK);

endmodule

// ===== rtl/core/arwc_checker.sv =====
// ----------------------------------------------------------------------------
// Anti-replay window check: port checker
// Port-level properties of the core, bound to the top level.
// ----------------------------------------------------------------------------
`include "anti_replay_window_check_core_defines.svh"

module arwc_checker
    import arwc_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_ready,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic       o_accepted,
    input logic [1:0] o_verdict
);

    // a stalled result holds
    `ARWC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_verdict) && $stable(o_accepted))

    // accepted flag agrees with the verdict
    `ARWC_ASSERT_NOW(a_acc_match, i_clk, i_rst_n, o_out_valid, o_accepted == (o_verdict == VERDICT_OK))

    // one item in flight: ready drops after an input transfer
    `ARWC_ASSERT_NEXT(a_one_item, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready)

    // a fresh result comes with the core going back to idle
    `ARWC_ASSERT_NOW(a_res_idle, i_clk, i_rst_n, $rose(o_out_valid), $rose(o_in_ready))

endmodule

bind anti_replay_window_check_core arwc_checker u_arwc_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_valid (i_in_valid),
    .o_in_ready (o_in_ready),
    .o_out_valid(o_out_valid),
    .i_out_ready(i_out_ready),
    .o_accepted (o_accepted),
    .o_verdict  (o_verdict)
);
